// File: rtl/cts_pkg.sv
// shared widths, constants, payload types and calendar tables for the civil time shifter
`default_nettype none
package cts_pkg;

  localparam int YEAR_W  = 12;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int EPOCH_W = 32;
  localparam int SHIFT_W = 17;
  localparam int DAYS_W  = 22;
  localparam int ZP_W    = 21;
  localparam int TOD_W   = 17;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 17'd30;

  // payload handed from the forward half to the back conversion
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [ZP_W-1:0]    zp;
    logic [TOD_W-1:0]   rem;
  } mid_t;

  // days before the first of each month, non-leap; codes outside 1..12 add nothing
  function automatic logic [8:0] month_start(input logic [MON_W-1:0] mon);
    logic [8:0] d;
    case (mon)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // day of a march-based year at which month index mp starts
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cts_in_if.sv
// request channel carrying one civil date and time
`default_nettype none
interface cts_in_if;
  import cts_pkg::*;
  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] in_year;
  logic [MON_W-1:0]  in_month;
  logic [DAY_W-1:0]  in_day;
  logic [HOUR_W-1:0] in_hour;
  logic [MIN_W-1:0]  in_minute;
  logic [SEC_W-1:0]  in_second;

  modport source (output valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
                  input ready);
  modport sink   (input valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/cts_out_if.sv
// result channel carrying epoch seconds and the shifted civil time
`default_nettype none
interface cts_out_if;
  import cts_pkg::*;
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic [YEAR_W-1:0]  out_year;
  logic [MON_W-1:0]   out_month;
  logic [DAY_W-1:0]   out_day;
  logic [HOUR_W-1:0]  out_hour;
  logic [MIN_W-1:0]   out_minute;
  logic [SEC_W-1:0]   out_second;

  modport source (output valid, epoch_seconds, out_year, out_month, out_day, out_hour,
                  out_minute, out_second, input ready);
  modport sink   (input valid, epoch_seconds, out_year, out_month, out_day, out_hour,
                  out_minute, out_second, output ready);
endinterface
`default_nettype wire

// File: rtl/cts_cfg_if.sv
// write channel for the shift register
`default_nettype none
interface cts_cfg_if;
  import cts_pkg::*;
  logic               valid;
  logic               ready;
  logic [SHIFT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/civil_time_offset_shift.sv
// top level: civil time to epoch seconds, shift, and back to civil time
`default_nettype none
// Takes a UTC date and time (year, month, day, hour, minute, second), returns its
// seconds since 1970 (mod 2^32) and the gregorian date and time of that instant plus
// the programmed shift (reset value 30 s). One request is accepted every cycle while
// the pipeline is not held by a stall at the result side; each request passes through
// the eight register stages in order, and its result waits in the last stage while the result
// side holds off. Stages with a free slot keep filling while the output waits, so no
// request is lost or repeated under any pattern of stalls. Months outside 1..12 count
// as january and out-of-range days, hours, minutes and seconds roll into the
// neighbouring unit.
// The shift register is written through its own channel, which is always ready;
// write it only while no request is in flight.
module civil_time_offset_shift (
  input  logic       clk,
  input  logic       rst,
  cts_cfg_if.sink    shift_cfg,
  cts_in_if.sink     event_time,
  cts_out_if.source  shifted_time
);
  import cts_pkg::*;

  // programmed shift in seconds
  logic [SHIFT_W-1:0] shift;

  // hand-off between the forward and back halves
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  assign shift_cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= SHIFT_RESET;
    end else if (shift_cfg.valid) begin
      shift <= shift_cfg.data;
    end
  end

  // stages 1 to 3: leap rules, day count, epoch seconds, shifted day index
  cts_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .shift     (shift),
    .src       (event_time),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // stages 4 to 8: era split, year of era, month and day, time of day
  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .dst       (shifted_time)
  );

  a_shift_reset: assert property (@(posedge clk)
    rst |=> (shift == SHIFT_RESET))
    else $error("shift register not at reset value after reset");

  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    shift_cfg.valid |=> (shift == $past(shift_cfg.data)))
    else $error("shift register missed a write");

endmodule
`default_nettype wire

// File: rtl/cts_fwd.sv
// forward half: civil time to day count, epoch seconds and shifted day index
`default_nettype none
module cts_fwd (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cts_pkg::SHIFT_W-1:0] shift,
  cts_in_if.sink                      src,
  output logic                        mid_valid,
  input  logic                        mid_ready,
  output cts_pkg::mid_t               mid
);
  import cts_pkg::*;

  logic en1, en2, en3;
  logic s1_valid, s2_valid, s3_valid;

  // stage 1: leap flag, leap day count, time of day
  logic [17:0]       ya_prod;
  logic [5:0]        qa_e, qa;
  logic [11:0]       ra_e;
  logic              a_hi, ra_zero, leap_next;
  logic [12:0]       m399, rb_e;
  logic [18:0]       mb_prod;
  logic [5:0]        qb_e, qb;
  logic [10:0]       lc_next;
  logic [TOD_W-1:0]  tod_next;

  logic [YEAR_W-1:0] s1_year;
  logic [MON_W-1:0]  s1_mon;
  logic [DAY_W-1:0]  s1_day;
  logic              s1_leap;
  logic [10:0]       s1_lc;
  logic [TOD_W-1:0]  s1_tod;

  always_comb begin
    ya_prod   = 18'(src.in_year) * 18'd40;
    qa_e      = ya_prod[17:12];
    ra_e      = src.in_year - 12'(qa_e) * 12'd100;
    a_hi      = (ra_e >= 12'd100);
    qa        = qa_e + 6'(a_hi);
    ra_zero   = a_hi ? (ra_e == 12'd100) : (ra_e == 12'd0);
    leap_next = (src.in_year[1:0] == 2'b00) && (!ra_zero || (qa[1:0] == 2'b00));

    m399      = 13'(src.in_year) + 13'd399;
    mb_prod   = 19'(m399) * 19'd81;
    qb_e      = mb_prod[18:13];
    rb_e      = m399 - 13'(qb_e) * 13'd100;
    qb        = qb_e + 6'(rb_e >= 13'd100);
    lc_next   = m399[12:2] - 11'(qb) + 11'(qb[5:2]);

    tod_next  = 17'(src.in_hour) * 17'd3600 + 17'(src.in_minute) * 17'd60
              + 17'(src.in_second);
  end

  // stage 2: day count, shifted time of day split into day carry and remainder
  logic [DAYS_W-1:0] days_next;
  logic              leap_adj;
  logic [17:0]       ts;
  logic [1:0]        qd_next;
  logic [TOD_W-1:0]  rem_next;

  logic [DAYS_W-1:0] s2_days;
  logic [TOD_W-1:0]  s2_tod;
  logic [TOD_W-1:0]  s2_rem;
  logic [1:0]        s2_qd;

  always_comb begin
    leap_adj  = s1_leap && (s1_mon >= 4'd3) && (s1_mon <= 4'd12);
    days_next = 22'(s1_year) * 22'd365 + 22'(s1_lc) + 22'(month_start(s1_mon))
              + 22'(s1_day) + 22'(leap_adj) - 22'd719625;
    ts        = 18'(s1_tod) + 18'(shift);
    if (ts >= 18'd172800) begin
      qd_next  = 2'd2;
      rem_next = 17'(ts - 18'd172800);
    end else if (ts >= 18'd86400) begin
      qd_next  = 2'd1;
      rem_next = 17'(ts - 18'd86400);
    end else begin
      qd_next  = 2'd0;
      rem_next = 17'(ts);
    end
  end

  // stage 3: epoch seconds and offset day index for the back conversion
  logic [EPOCH_W-1:0] days_x;
  logic [DAYS_W-1:0]  zp_sum;
  mid_t               mid_next;

  always_comb begin
    days_x         = {{(EPOCH_W-DAYS_W){s2_days[DAYS_W-1]}}, s2_days};
    mid_next.epoch = days_x * 32'd86400 + 32'(s2_tod);
    zp_sum         = s2_days + 22'(s2_qd) + 22'd865565;
    mid_next.zp    = zp_sum[ZP_W-1:0];
    mid_next.rem   = s2_rem;
  end

  assign en3       = !s3_valid || mid_ready;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign src.ready = en1;
  assign mid_valid = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= src.valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year <= src.in_year;
      s1_mon  <= src.in_month;
      s1_day  <= src.in_day;
      s1_leap <= leap_next;
      s1_lc   <= lc_next;
      s1_tod  <= tod_next;
    end
    if (en2) begin
      s2_days <= days_next;
      s2_tod  <= s1_tod;
      s2_rem  <= rem_next;
      s2_qd   <= qd_next;
    end
    if (en3) begin
      mid <= mid_next;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_rem < 17'd86400))
    else $error("time of day remainder not below one day");

endmodule
`default_nettype wire

// File: rtl/cts_back.sv
// back half: shifted day index and remainder to gregorian date and time
`default_nettype none
module cts_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          mid_valid,
  output logic          mid_ready,
  input  cts_pkg::mid_t mid,
  cts_out_if.source     dst
);
  import cts_pkg::*;

  logic en4, en5, en6, en7, en8;
  logic s4_valid, s5_valid, s6_valid, s7_valid, s8_valid;

  // stage 4: era and day of era, hour
  logic [24:0]  ep;
  logic [3:0]   ea_e, era_next;
  logic [20:0]  rd;
  logic         e_hi;
  logic [17:0]  doe_next;
  logic [21:0]  hp;
  logic [4:0]   hq_e, hour_next;
  logic [12:0]  rh;
  logic         h_hi;
  logic [11:0]  r1_next;

  logic [EPOCH_W-1:0] s4_epoch;
  logic [3:0]         s4_era;
  logic [17:0]        s4_doe;
  logic [4:0]         s4_hour;
  logic [11:0]        s4_r1;

  always_comb begin
    ep        = 25'(mid.zp) * 25'd14;
    ea_e      = ep[24:21];
    rd        = mid.zp - 21'(ea_e) * 21'd146097;
    e_hi      = (rd >= 21'd146097);
    era_next  = ea_e + 4'(e_hi);
    doe_next  = e_hi ? 18'(rd - 21'd146097) : 18'(rd);

    hp        = 22'(mid.rem) * 22'd36;
    hq_e      = hp[21:17];
    rh        = 13'(mid.rem - 17'(hq_e) * 17'd3600);
    h_hi      = (rh >= 13'd3600);
    hour_next = hq_e + 5'(h_hi);
    r1_next   = h_hi ? 12'(rh - 13'd3600) : 12'(rh);
  end

  // stage 5: adjusted day of era for the year divide, minute and second
  logic [24:0]  dp;
  logic [6:0]   q1e, q1;
  logic [17:0]  r4y;
  logic [2:0]   q2;
  logic         q3;
  logic [17:0]  num_next;
  logic [17:0]  mprod;
  logic [5:0]   me, minute_next, second_next;
  logic [6:0]   rm;
  logic         m_hi;

  logic [EPOCH_W-1:0] s5_epoch;
  logic [3:0]         s5_era;
  logic [17:0]        s5_doe, s5_num;
  logic [4:0]         s5_hour;
  logic [5:0]         s5_minute, s5_second;

  always_comb begin
    dp          = 25'(s4_doe) * 25'd179;
    q1e         = dp[24:18];
    r4y         = s4_doe - 18'(q1e) * 18'd1460;
    q1          = q1e + 7'(r4y >= 18'd1460);
    q2          = 3'(s4_doe >= 18'd36524) + 3'(s4_doe >= 18'd73048)
                + 3'(s4_doe >= 18'd109572) + 3'(s4_doe >= 18'd146096);
    q3          = (s4_doe == 18'd146096);
    num_next    = s4_doe - 18'(q1) + 18'(q2) - 18'(q3);

    mprod       = 18'(s4_r1) * 18'd68;
    me          = mprod[17:12];
    rm          = 7'(s4_r1 - 12'(me) * 12'd60);
    m_hi        = (rm >= 7'd60);
    minute_next = me + 6'(m_hi);
    second_next = m_hi ? 6'(rm - 7'd60) : 6'(rm);
  end

  // stage 6: year of era
  logic [26:0] np;
  logic [8:0]  ye, yoe_next;
  logic [17:0] ry;

  logic [EPOCH_W-1:0] s6_epoch;
  logic [3:0]         s6_era;
  logic [17:0]        s6_doe;
  logic [8:0]         s6_yoe;
  logic [4:0]         s6_hour;
  logic [5:0]         s6_minute, s6_second;

  always_comb begin
    np       = 27'(s5_num) * 27'd718;
    ye       = np[26:18];
    ry       = s5_num - 18'(ye) * 18'd365;
    yoe_next = ye + 9'(ry >= 18'd365);
  end

  // stage 7: day of the march-based year
  logic [1:0]  yc;
  logic [17:0] ybase;
  logic [8:0]  doy_next;

  logic [EPOCH_W-1:0] s7_epoch;
  logic [3:0]         s7_era;
  logic [8:0]         s7_yoe, s7_doy;
  logic [4:0]         s7_hour;
  logic [5:0]         s7_minute, s7_second;

  always_comb begin
    yc       = 2'(s6_yoe >= 9'd100) + 2'(s6_yoe >= 9'd200) + 2'(s6_yoe >= 9'd300);
    ybase    = 18'(s6_yoe) * 18'd365 + 18'(s6_yoe[8:2]) - 18'(yc);
    doy_next = 9'(s6_doe - ybase);
  end

  // stage 8: month, day and calendar year
  logic [10:0] x5;
  logic [14:0] xp;
  logic [3:0]  mpe, mp;
  logic [10:0] rx;
  logic [8:0]  dsum;
  logic        yinc;
  logic [MON_W-1:0]  month_next;
  logic [DAY_W-1:0]  day_next;
  logic [YEAR_W-1:0] year_next;

  always_comb begin
    x5         = 11'(s7_doy) * 11'd5 + 11'd2;
    xp         = 15'(x5) * 15'd13;
    mpe        = xp[14:11];
    rx         = x5 - 11'(mpe) * 11'd153;
    mp         = mpe + 4'(rx >= 11'd153);
    dsum       = s7_doy - mp_start(mp) + 9'd1;
    day_next   = dsum[DAY_W-1:0];
    yinc       = (mp >= 4'd10);
    month_next = yinc ? (mp - 4'd9) : (mp + 4'd3);
    // era counted from one below, so the year carries a 400 year offset mod 4096
    year_next  = 12'(s7_yoe) + 12'(s7_era) * 12'd400 + 12'(yinc) + 12'd3696;
  end

  assign en8       = !s8_valid || dst.ready;
  assign en7       = !s7_valid || en8;
  assign en6       = !s6_valid || en7;
  assign en5       = !s5_valid || en6;
  assign en4       = !s4_valid || en5;
  assign mid_ready = en4;
  assign dst.valid = s8_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      if (en4) s4_valid <= mid_valid;
      if (en5) s5_valid <= s4_valid;
      if (en6) s6_valid <= s5_valid;
      if (en7) s7_valid <= s6_valid;
      if (en8) s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_epoch <= mid.epoch;
      s4_era   <= era_next;
      s4_doe   <= doe_next;
      s4_hour  <= hour_next;
      s4_r1    <= r1_next;
    end
    if (en5) begin
      s5_epoch  <= s4_epoch;
      s5_era    <= s4_era;
      s5_doe    <= s4_doe;
      s5_num    <= num_next;
      s5_hour   <= s4_hour;
      s5_minute <= minute_next;
      s5_second <= second_next;
    end
    if (en6) begin
      s6_epoch  <= s5_epoch;
      s6_era    <= s5_era;
      s6_doe    <= s5_doe;
      s6_yoe    <= yoe_next;
      s6_hour   <= s5_hour;
      s6_minute <= s5_minute;
      s6_second <= s5_second;
    end
    if (en7) begin
      s7_epoch  <= s6_epoch;
      s7_era    <= s6_era;
      s7_yoe    <= s6_yoe;
      s7_doy    <= doy_next;
      s7_hour   <= s6_hour;
      s7_minute <= s6_minute;
      s7_second <= s6_second;
    end
    if (en8) begin
      dst.epoch_seconds <= s7_epoch;
      dst.out_year      <= year_next;
      dst.out_month     <= month_next;
      dst.out_day       <= day_next;
      dst.out_hour      <= s7_hour;
      dst.out_minute    <= s7_minute;
      dst.out_second    <= s7_second;
    end
  end

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    s8_valid |-> (dst.out_month >= 4'd1) && (dst.out_month <= 4'd12))
    else $error("month outside 1..12");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    s8_valid |-> (dst.out_day != 5'd0))
    else $error("day of month is zero");

  a_hms_range: assert property (@(posedge clk) disable iff (rst)
    s8_valid |-> (dst.out_hour < 5'd24) && (dst.out_minute < 6'd60)
                 && (dst.out_second < 6'd60))
    else $error("time of day field out of range");

endmodule
`default_nettype wire
